>>> hdl/tmfb_pkg.sv
// shared types and constants of the timestamp match frame buffer
`timescale 1ns / 1ps

package tmfb_pkg;

   // default sizes
   localparam int CAMERA_COUNT_DEF = 4;
   localparam int FIFO_DEPTH_DEF   = 16;
   localparam int HANDLE_BITS_DEF  = 32;

   // fixed field widths
   localparam int STAMP_BITS  = 63;
   localparam int TOL_BITS    = 32;
   localparam int IN_HANDLE_BITS = 32;

   // action codes
   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_TAKE  = 2'd1,
      ACT_MATCH = 2'd2
   } action_type;

   // token travelling down the cell chain
   typedef struct packed {
      logic tok;
      logic hit;
   } scan_type;

endpackage

>>> hdl/tmfb_cell.sv
// one FIFO position of every camera, with its stage of the nearest stamp scan
`timescale 1ns / 1ps

module tmfb_cell #(
   parameter int CAMERA_COUNT = tmfb_pkg::CAMERA_COUNT_DEF,
   parameter int FIFO_DEPTH   = tmfb_pkg::FIFO_DEPTH_DEF,
   parameter int HANDLE_BITS  = tmfb_pkg::HANDLE_BITS_DEF,
   parameter int K            = 0,
   localparam int CB = (CAMERA_COUNT > 1) ? $clog2(CAMERA_COUNT) : 1,
   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
   localparam int CW = $clog2(FIFO_DEPTH + 1),
   localparam int SB = tmfb_pkg::STAMP_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CB-1:0]          wr_cam,
   input  logic [PW-1:0]          wr_slot,
   input  logic [SB-1:0]          wr_stamp,
   input  logic [HANDLE_BITS-1:0] wr_handle,
   input  logic [CB-1:0]          rd_cam,
   input  logic                   match_mode,
   input  logic [PW-1:0]          head,
   input  logic [CW-1:0]          count,
   input  logic [SB-1:0]          target,
   input  tmfb_pkg::scan_type     in_ctl,
   input  logic [SB-1:0]          in_diff,
   input  logic [PW-1:0]          in_pos,
   input  logic [SB-1:0]          in_stamp,
   input  logic [HANDLE_BITS-1:0] in_handle,
   output tmfb_pkg::scan_type     out_ctl,
   output logic [SB-1:0]          out_diff,
   output logic [PW-1:0]          out_pos,
   output logic [SB-1:0]          out_stamp,
   output logic [HANDLE_BITS-1:0] out_handle
);

   localparam int SW = CW + 1;

   logic [SB-1:0]          stamps_ff  [CAMERA_COUNT];
   logic [HANDLE_BITS-1:0] handles_ff [CAMERA_COUNT];
   tmfb_pkg::scan_type     ctl_ff;
   logic [SB-1:0]          diff_ff;
   logic [PW-1:0]          pos_ff;
   logic [SB-1:0]          stamp_ff;
   logic [HANDLE_BITS-1:0] handle_ff;

   logic [SW-1:0]          lidx;
   logic                   live;
   logic [SB-1:0]          own_stamp;
   logic [SB-1:0]          own_diff;
   logic                   take_in;

   // age of this slot within the addressed fifo
   always_comb begin
      if (SW'(K) >= SW'(head)) begin
         lidx = SW'(K) - SW'(head);
      end else begin
         lidx = SW'(K) + SW'(FIFO_DEPTH) - SW'(head);
      end
      live = lidx < SW'(count);
   end

   // distance to the target and the choice of this slot
   always_comb begin
      own_stamp = stamps_ff[rd_cam];
      own_diff  = (own_stamp > target) ? (own_stamp - target) : (target - own_stamp);
      take_in   = 1'b0;
      if (live) begin
         if (match_mode) begin
            take_in = !in_ctl.hit || (own_diff < in_diff) ||
                      ((own_diff == in_diff) && (PW'(lidx) < in_pos));
         end else begin
            take_in = (lidx == SW'(count) - SW'(1));
         end
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (wr_en && (wr_slot == PW'(K))) begin
         stamps_ff[wr_cam]  <= wr_stamp;
         handles_ff[wr_cam] <= wr_handle;
      end
   end

   // hand the best so far to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff.tok <= in_ctl.tok;
         ctl_ff.hit <= in_ctl.hit || take_in;
      end
      if (take_in) begin
         diff_ff   <= own_diff;
         pos_ff    <= PW'(lidx);
         stamp_ff  <= own_stamp;
         handle_ff <= handles_ff[rd_cam];
      end else begin
         diff_ff   <= in_diff;
         pos_ff    <= in_pos;
         stamp_ff  <= in_stamp;
         handle_ff <= in_handle;
      end
   end

   assign out_ctl    = ctl_ff;
   assign out_diff   = diff_ff;
   assign out_pos    = pos_ff;
   assign out_stamp  = stamp_ff;
   assign out_handle = handle_ff;

endmodule

>>> hdl/timestamp_match_frame_buffer_top.sv
// top level of the timestamp match frame buffer
`timescale 1ns / 1ps

// Holds one bounded fifo of (stamp, handle) entries per camera. A push is
// taken and gives no result. A take-latest or a match sends a token down
// a chain of FIFO_DEPTH cells, one cell a cycle, each cell holding one
// fifo position of every camera and keeping the nearest entry so far, or
// the newest for a take-latest; the result is registered once the token
// leaves the chain, and an empty fifo or an unknown camera answers
// without a scan. A new item is taken once the previous one has its
// result in the output register.

module timestamp_match_frame_buffer_top #(
   parameter int CAMERA_COUNT = tmfb_pkg::CAMERA_COUNT_DEF,
   parameter int FIFO_DEPTH   = tmfb_pkg::FIFO_DEPTH_DEF,
   parameter int HANDLE_BITS  = tmfb_pkg::HANDLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // camera_index [1:0], time_stamp [64:2], frame_handle [96:65],
   // tolerance [128:97], zeros [135:129]
   input  logic [135:0] req_tdata,
   // action [1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_handle [31:0], out_stamp [94:32], zero [95]
   output logic [95:0]  rsp_tdata,
   // found [0]
   output logic [0:0]   rsp_tuser
);

   localparam int CB = (CAMERA_COUNT > 1) ? $clog2(CAMERA_COUNT) : 1;
   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int SB = tmfb_pkg::STAMP_BITS;
   localparam int HB = HANDLE_BITS;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type              state_ff;
   logic [PW-1:0]          heads_ff  [CAMERA_COUNT];
   logic [CW-1:0]          counts_ff [CAMERA_COUNT];
   logic [CB-1:0]          cam_ff;
   logic [SB-1:0]          target_ff;
   logic [tmfb_pkg::TOL_BITS-1:0] tol_ff;
   logic                   match_ff;
   logic [PW-1:0]          head_ff;
   logic [CW-1:0]          count_ff;
   logic                   start_ff;
   logic                   res_found_ff;
   logic [31:0]            res_handle_ff;
   logic [SB-1:0]          res_stamp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [31:0]            rsp_handle_ff;
   logic [SB-1:0]          rsp_stamp_ff;

   tmfb_pkg::action_type   req_action;
   logic [1:0]             req_cam;
   logic [SB-1:0]          req_stamp;
   logic [tmfb_pkg::IN_HANDLE_BITS-1:0] req_handle;
   logic [tmfb_pkg::TOL_BITS-1:0] req_tol;
   logic                   accept;
   logic                   cam_ok;
   logic [CB-1:0]          cam_sel;
   logic [PW-1:0]          head_cur;
   logic [CW-1:0]          count_cur;
   logic                   full;
   logic [SW-1:0]          tail_sum;
   logic                   wr_en;
   logic [PW-1:0]          wr_slot;
   logic [PW-1:0]          head_in;
   logic [CW-1:0]          count_in;
   logic                   found_in;
   logic [SW-1:0]          adv_sum;
   logic [PW-1:0]          adv_head_in;
   logic [CW-1:0]          adv_count_in;
   logic                   out_free;

   tmfb_pkg::scan_type     chain_ctl    [FIFO_DEPTH+1];
   logic [SB-1:0]          chain_diff   [FIFO_DEPTH+1];
   logic [PW-1:0]          chain_pos    [FIFO_DEPTH+1];
   logic [SB-1:0]          chain_stamp  [FIFO_DEPTH+1];
   logic [HB-1:0]          chain_handle [FIFO_DEPTH+1];

   // request fields
   assign req_action = tmfb_pkg::action_type'(req_tuser);
   assign req_cam    = req_tdata[1:0];
   assign req_stamp  = req_tdata[64:2];
   assign req_handle = req_tdata[96:65];
   assign req_tol    = req_tdata[128:97];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cam_ok     = (32'(req_cam) < CAMERA_COUNT);
   assign cam_sel    = CB'(req_cam);
   assign head_cur   = heads_ff[cam_sel];
   assign count_cur  = counts_ff[cam_sel];

   // push placement
   always_comb begin
      full     = (32'(count_cur) >= FIFO_DEPTH);
      tail_sum = SW'(head_cur) + SW'(count_cur);
      if (full) begin
         wr_slot  = head_cur;
         head_in  = (head_cur == PW'(FIFO_DEPTH - 1)) ? '0 : head_cur + PW'(1);
         count_in = count_cur;
      end else begin
         wr_slot  = (tail_sum >= SW'(FIFO_DEPTH)) ? PW'(tail_sum - SW'(FIFO_DEPTH))
                                                  : PW'(tail_sum);
         head_in  = head_cur;
         count_in = count_cur + CW'(1);
      end
      wr_en = accept && (req_action == tmfb_pkg::ACT_PUSH) && cam_ok;
   end

   // outcome at the end of the chain
   always_comb begin
      if (match_ff) begin
         found_in = chain_ctl[FIFO_DEPTH].hit &&
                    (chain_diff[FIFO_DEPTH] <= SB'(tol_ff));
      end else begin
         found_in = chain_ctl[FIFO_DEPTH].hit;
      end
      adv_sum      = SW'(head_ff) + SW'(chain_pos[FIFO_DEPTH]) + SW'(1);
      adv_head_in  = (adv_sum >= SW'(FIFO_DEPTH)) ? PW'(adv_sum - SW'(FIFO_DEPTH))
                                                  : PW'(adv_sum);
      adv_count_in = count_ff - CW'(chain_pos[FIFO_DEPTH]) - CW'(1);
      out_free     = !rsp_valid_ff || rsp_tready;
   end

   // chain of cells
   assign chain_ctl[0]    = '{tok: start_ff, hit: 1'b0};
   assign chain_diff[0]   = '0;
   assign chain_pos[0]    = '0;
   assign chain_stamp[0]  = '0;
   assign chain_handle[0] = '0;

   for (genvar k = 0; k < FIFO_DEPTH; k++) begin : g_cell
      tmfb_cell #(
         .CAMERA_COUNT (CAMERA_COUNT),
         .FIFO_DEPTH   (FIFO_DEPTH),
         .HANDLE_BITS  (HANDLE_BITS),
         .K            (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_en),
         .wr_cam     (cam_sel),
         .wr_slot    (wr_slot),
         .wr_stamp   (req_stamp),
         .wr_handle  (HB'(req_handle)),
         .rd_cam     (cam_ff),
         .match_mode (match_ff),
         .head       (head_ff),
         .count      (count_ff),
         .target     (target_ff),
         .in_ctl     (chain_ctl[k]),
         .in_diff    (chain_diff[k]),
         .in_pos     (chain_pos[k]),
         .in_stamp   (chain_stamp[k]),
         .in_handle  (chain_handle[k]),
         .out_ctl    (chain_ctl[k+1]),
         .out_diff   (chain_diff[k+1]),
         .out_pos    (chain_pos[k+1]),
         .out_stamp  (chain_stamp[k+1]),
         .out_handle (chain_handle[k+1])
      );
   end

   // control sequencer, fifo pointers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CAMERA_COUNT; c++) begin
            heads_ff[c]  <= '0;
            counts_ff[c] <= '0;
         end
      end else begin
         start_ff <= 1'b0;
         // result taken; a new one is loaded only from the done state
         if (rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cam_ff    <= cam_sel;
                  target_ff <= req_stamp;
                  tol_ff    <= req_tol;
                  match_ff  <= (req_action == tmfb_pkg::ACT_MATCH);
                  head_ff   <= head_cur;
                  count_ff  <= count_cur;
                  case (req_action)
                     tmfb_pkg::ACT_PUSH: begin
                        if (cam_ok) begin
                           heads_ff[cam_sel]  <= head_in;
                           counts_ff[cam_sel] <= count_in;
                        end
                     end
                     tmfb_pkg::ACT_TAKE, tmfb_pkg::ACT_MATCH: begin
                        if (!cam_ok || (count_cur == '0)) begin
                           res_found_ff  <= 1'b0;
                           res_handle_ff <= '0;
                           res_stamp_ff  <= '0;
                           state_ff      <= ST_DONE;
                        end else begin
                           start_ff <= 1'b1;
                           state_ff <= ST_SCAN;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (chain_ctl[FIFO_DEPTH].tok) begin
                  res_found_ff  <= found_in;
                  res_handle_ff <= found_in ? 32'(chain_handle[FIFO_DEPTH]) : '0;
                  res_stamp_ff  <= found_in ? chain_stamp[FIFO_DEPTH] : '0;
                  if (found_in) begin
                     if (match_ff) begin
                        heads_ff[cam_ff]  <= adv_head_in;
                        counts_ff[cam_ff] <= adv_count_in;
                     end else begin
                        counts_ff[cam_ff] <= '0;
                     end
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_found_ff  <= res_found_ff;
                  rsp_handle_ff <= res_handle_ff;
                  rsp_stamp_ff  <= res_stamp_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_stamp_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule
